[sv/sha256_pkg.sv]
// ============================================================================
// SHA-256 hasher package
// Shared types, round constants, initial hash values and the mixing
// functions used by the SHA-256 message hasher.
// ============================================================================
package sha256_pkg;

    // One input word: a message byte and its marks.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    // One output word: a digest word and its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Eight 32-bit hash words, index 0 is the first digest word.
    typedef logic [7:0][31:0] hash_words_t;

    // Commands from the byte sequencer to the compression unit.
    typedef struct packed {
        logic        push;
        logic [31:0] word;
        logic        start;
        logic        init;
    } comp_cmd_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Padding marker byte that follows the last message byte.
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Byte position at which the length field starts.
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[sv/sha256_compress.sv]
// ============================================================================
// SHA-256 compression unit
// Holds the chaining value and a 16-word schedule window. Runs one round
// per cycle through all 64 rounds, then folds the working variables into
// the chaining value.
// ============================================================================
module sha256_compress (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha256_pkg::comp_cmd_t   cmd,
    output logic                    busy,
    output sha256_pkg::hash_words_t chain
);
    import sha256_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_UPDATE
    } cstate_t;

    cstate_t     state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    hash_words_t chain_reg, chain_next;
    hash_words_t wv_reg, wv_next;
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] sched_new;

    // Round function on the working variables a..h (index 0..7).
    always_comb
    begin
        ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1  = wv_reg[7] + big_sigma1(wv_reg[4]) + ch + ROUND_K[round_reg] + win_reg[0];
        t2  = big_sigma0(wv_reg[0]) + maj;
        sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                  + small_sigma0(win_reg[1]) + win_reg[0];
    end

    // Sequencer and next values.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        wv_next    = wv_reg;
        win_next   = win_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.push)
                begin
                    for (int i = 0; i < 15; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[15] = cmd.word;
                end
                if (cmd.init)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_next[i] = INIT_HASH[i];
                    end
                end
                if (cmd.start)
                begin
                    wv_next    = chain_reg;
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = sched_new;
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = C_UPDATE;
                end
            end
            C_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + wv_reg[i];
                end
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Control state and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    // Working variables and schedule window.
    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        win_reg <= win_next;
    end

    assign busy  = (state_reg != C_IDLE);
    assign chain = chain_reg;

endmodule

[sv/sha256_message_hasher_core.sv]
// ============================================================================
// SHA-256 message hasher
// Hashes a byte stream with standard SHA-256 and returns eight digest words
// for each message.
// ============================================================================
// Usage:
// The item channel (item_valid, item_stall, item) carries one message byte
// per word, with a present flag and an end-of-message mark. The digest
// channel (digest_valid, digest_stall, digest) returns eight words per
// message, word_index 0 to 7, last_word set on the eighth.
// A plain byte is taken while item_stall is low. The byte that fills a
// 64-byte block starts the compression unit, which runs one round per
// cycle; item_stall then stays high for the 64 rounds, the chaining update
// and the handoff. An end mark inserts padding one byte per cycle (9 to 72
// bytes) between compressions, compresses one or two final blocks and then
// presents the digest words, one per cycle while digest_stall is low. A
// stalled digest word holds. Only one message item is in flight; item_stall
// is high from the end mark until the last digest word is taken.
// Reset loads the initial hash values and clears the byte and bit counts.
// ============================================================================
module sha256_message_hasher_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sha256_pkg::in_item_t  item,
    output logic                  digest_valid,
    input  logic                  digest_stall,
    output sha256_pkg::out_item_t digest
);
    import sha256_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_WAIT,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [23:0] acc_reg, acc_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        len_phase_reg, len_phase_next;
    logic [2:0]  idx_reg, idx_next;

    logic        push_en;
    logic [7:0]  push_data;
    comp_cmd_t   cmd;
    logic        comp_busy;
    hash_words_t chain;

    sha256_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .busy  (comp_busy),
        .chain (chain)
    );

    // Byte sequencer: message bytes, padding bytes and digest output.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        bit_count_next = bit_count_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        len_phase_next = len_phase_reg;
        idx_next       = idx_reg;
        push_en        = 1'b0;
        push_data      = '0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.byte_present)
                    begin
                        push_en        = 1'b1;
                        push_data      = item.data_byte;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (item.end_of_message)
                    begin
                        pad_next       = 1'b1;
                        first_next     = 1'b1;
                        len_phase_next = 1'b0;
                        state_next     = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                push_en = 1'b1;
                if (first_reg)
                begin
                    push_data  = PAD_MARK;
                    first_next = 1'b0;
                end
                else if (!len_phase_reg && (pos_reg != LEN_START))
                begin
                    push_data = '0;
                end
                else
                begin
                    // Length field, most significant byte first.
                    push_data      = bit_count_reg[{~pos_reg[2:0], 3'b000} +: 8];
                    len_phase_next = 1'b1;
                end
            end
            S_WAIT:
            begin
                if (!comp_busy)
                begin
                    if (!pad_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (len_phase_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_OUT:
            begin
                if (!digest_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        // Back to the initial values for the next message.
                        cmd.init       = 1'b1;
                        pos_next       = '0;
                        bit_count_next = '0;
                        pad_next       = 1'b0;
                        first_next     = 1'b0;
                        len_phase_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Gather bytes into big-endian words and start a block when full.
        if (push_en)
        begin
            acc_next = {acc_reg[15:0], push_data};
            pos_next = pos_reg + 6'd1;
            if (pos_reg[1:0] == 2'b11)
            begin
                cmd.push = 1'b1;
                cmd.word = {acc_reg, push_data};
            end
            if (pos_reg == 6'd63)
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            bit_count_reg <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            len_phase_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bit_count_reg <= bit_count_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            len_phase_reg <= len_phase_next;
            idx_reg       <= idx_next;
        end
    end

    // Partial word of gathered bytes.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign item_stall         = (state_reg != S_IDLE);
    assign digest_valid       = (state_reg == S_OUT);
    assign digest.digest_word = chain[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 3'd7);

endmodule

[tb/sv/sha256_digest_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 digest checker
// Watches the item and digest channels of the message hasher. It keeps its
// own running SHA-256 state, works out the eight digest words for every
// message end it sees accepted, and compares each accepted digest word
// against the oldest expected one.
// ============================================================================
module sha256_digest_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  sha256_pkg::in_item_t  item,
    input  logic                  digest_valid,
    input  logic                  digest_stall,
    input  sha256_pkg::out_item_t digest,
    output int                    error_count,
    output int                    words_pending,
    output int                    messages_done,
    output int                    bytes_done,
    output int                    words_checked
);
    import sha256_pkg::*;

    localparam int          REPORT_LIMIT     = 10;
    localparam logic [7:0]  PAD_BYTE         = 8'h80;
    localparam logic [5:0]  LENGTH_FIELD_POS = 6'd56;

    localparam logic [31:0] ROUND_WORDS [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Running hash state of the message in progress.
    logic [31:0] chain [8];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill;
    logic [63:0] bit_length;

    // Digest words that are due but have not been seen yet.
    out_item_t expected_digest_words [$];

    int fails;
    int msg_count;
    int byte_count;
    int checked_count;

    function automatic logic [31:0] rot_right(input logic [31:0] v, input int amt);
        return (v >> amt) | (v << (32 - amt));
    endfunction

    // Back to the initial hash value and an empty block.
    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = START_HASH[i];
        end
        fill       = '0;
        bit_length = '0;
    endtask

    // One 64-round compression of the full block into the chaining value.
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] wv [8];
        logic [31:0] s0, s1, t1, t2, ch, maj;
        for (int r = 0; r < 16; r++)
        begin
            sched[r] = {block_bytes[4 * r], block_bytes[4 * r + 1],
                        block_bytes[4 * r + 2], block_bytes[4 * r + 3]};
        end
        for (int r = 16; r < 64; r++)
        begin
            s0 = rot_right(sched[r - 15], 7) ^ rot_right(sched[r - 15], 18)
                 ^ (sched[r - 15] >> 3);
            s1 = rot_right(sched[r - 2], 17) ^ rot_right(sched[r - 2], 19)
                 ^ (sched[r - 2] >> 10);
            sched[r] = sched[r - 16] + s0 + sched[r - 7] + s1;
        end
        for (int i = 0; i < 8; i++)
        begin
            wv[i] = chain[i];
        end
        for (int r = 0; r < 64; r++)
        begin
            s1  = rot_right(wv[4], 6) ^ rot_right(wv[4], 11) ^ rot_right(wv[4], 25);
            ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
            t1  = wv[7] + s1 + ch + ROUND_WORDS[r] + sched[r];
            s0  = rot_right(wv[0], 2) ^ rot_right(wv[0], 13) ^ rot_right(wv[0], 22);
            maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
            t2  = s0 + maj;
            wv[7] = wv[6];
            wv[6] = wv[5];
            wv[5] = wv[4];
            wv[4] = wv[3] + t1;
            wv[3] = wv[2];
            wv[2] = wv[1];
            wv[1] = wv[0];
            wv[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = chain[i] + wv[i];
        end
    endtask

    // Append one byte to the block; a full block is compressed at once.
    task automatic add_byte(input logic [7:0] b);
        block_bytes[fill] = b;
        fill = fill + 6'd1;
        if (fill == 6'd0)
        begin
            compress_block();
        end
    endtask

    // Absorb one accepted item; an end mark pads, finishes and queues a digest.
    task automatic absorb_item(input in_item_t w);
        logic [63:0] len_snapshot;
        out_item_t   exp_word;
        if (w.byte_present)
        begin
            add_byte(w.data_byte);
            bit_length = bit_length + 64'd8;
            byte_count++;
        end
        if (w.end_of_message)
        begin
            len_snapshot = bit_length;
            add_byte(PAD_BYTE);
            while (fill != LENGTH_FIELD_POS)
            begin
                add_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                add_byte(len_snapshot[63 - 8 * i -: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                exp_word.digest_word = chain[i];
                exp_word.word_index  = 3'(i);
                exp_word.last_word   = (i == 7);
                expected_digest_words.insert(expected_digest_words.size(), exp_word);
            end
            msg_count++;
            restart_hash();
        end
    endtask

    // Compare one accepted digest word against the oldest expectation.
    task automatic check_digest_word(input out_item_t got);
        out_item_t want;
        if (expected_digest_words.size() == 0)
        begin
            fails++;
            if (fails <= REPORT_LIMIT)
            begin
                $display("%0t: unexpected digest word %h index %0d last %0b",
                         $realtime, got.digest_word, got.word_index, got.last_word);
            end
        end
        else
        begin
            want = expected_digest_words.pop_front();
            checked_count++;
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
                || got.last_word !== want.last_word)
            begin
                fails++;
                if (fails <= REPORT_LIMIT)
                begin
                    $display("%0t: digest mismatch: expected %h index %0d last %0b, got %h index %0d last %0b",
                             $realtime, want.digest_word, want.word_index, want.last_word,
                             got.digest_word, got.word_index, got.last_word);
                end
            end
        end
    endtask

    // Channel monitor: digest side first, then the item side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_hash();
            expected_digest_words.delete();
            fails         = 0;
            msg_count     = 0;
            byte_count    = 0;
            checked_count = 0;
        end
        else
        begin
            if (digest_valid && !digest_stall)
            begin
                check_digest_word(digest);
            end
            if (item_valid && !item_stall)
            begin
                absorb_item(item);
            end
        end
        error_count   <= fails;
        words_pending <= expected_digest_words.size();
        messages_done <= msg_count;
        bytes_done    <= byte_count;
        words_checked <= checked_count;
    end

endmodule

[tb/sv/sha256_message_hasher_core_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 message hasher testbench
// Feeds byte messages of many lengths into the hasher, with random gaps on
// the item side and random stalls on the digest side, and leaves all digest
// checking to the checker instance beside the block.
// ============================================================================
module sha256_message_hasher_core_test;
    import sha256_pkg::*;

    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_FROM   = 360;
    localparam int DRAIN_CYCLES = 50;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      digest_valid;
    logic      digest_stall;
    out_item_t digest;

    int error_count;
    int words_pending;
    int messages_done;
    int bytes_done;
    int words_checked;

    bit idling_on;
    int stall_left;
    int items_sent;

    sha256_message_hasher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    sha256_digest_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .digest_valid  (digest_valid),
        .digest_stall  (digest_stall),
        .digest        (digest),
        .error_count   (error_count),
        .words_pending (words_pending),
        .messages_done (messages_done),
        .bytes_done    (bytes_done),
        .words_checked (words_checked)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Digest-side stalls in random bursts while idling is enabled.
    initial
    begin
        digest_stall = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13);
            end
            digest_stall <= (stall_left > 0);
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic present, input logic last);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{data_byte: b, byte_present: present, end_of_message: last};
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        if (present || last)
        begin
            items_sent++;
        end
    endtask

    // A message of random bytes; the end mark rides on the last byte or
    // comes as a word of its own. Idle words are sprinkled in as noise.
    task automatic send_message(input int len, input bit fuse_end);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, (i == len - 1) && fuse_end);
        end
        if (!fuse_end || len == 0)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Mostly short messages, some right at the padding boundaries, a few long.
    function automatic int pick_length();
        int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return $urandom_range(0, 12);
        end
        else if (r < 93)
        begin
            return edges[$urandom_range(0, 7)];
        end
        return $urandom_range(13, 140);
    endfunction

    // Stimulus and verdict.
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        idling_on  = 1'b1;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty message, then an idle word with a stray data byte.
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'h5A, 1'b0, 1'b0);
        // Single-byte messages where the byte and the end mark come together.
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        // "abc" with the end on the last byte, then with a separate end word.
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // Extreme byte values with an idle word in the middle of a message.
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b1);
        // Two empty messages back to back.
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);

        // Random messages; the last stretch runs with no idling.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= QUIET_FROM)
            begin
                idling_on <= 1'b0;
            end
            send_message(pick_length(), 1'($urandom_range(0, 1)));
        end

        // Drain: wait for every outstanding digest word, then for the DRAIN_CYCLES period.
        item_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages holding %0d bytes; %0d digest words checked.",
                 messages_done, bytes_done, words_checked);
        $display("Mismatches or unexpected digest words: %0d", error_count);
        if (error_count == 0 && words_pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
